[rtl/gmp_pkg.sv]
// Shared constants and register codes for the grid maximum path block.
package gmp_pkg;

   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS_DEF   = 1024;
   localparam int VALUE_BITS_DEF = 16;
   localparam int SUM_BITS_DEF   = 32;

   localparam int CSR_BITS      = 11;
   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_NUM_ROWS   = 3'd0,
      REG_NUM_COLS   = 3'd1,
      REG_WALL_ROW_A = 3'd2,
      REG_WALL_COL_A = 3'd3,
      REG_WALL_ROW_B = 3'd4,
      REG_WALL_COL_B = 3'd5
   } csr_reg_type;

endpackage

[rtl/grid_max_path_with_wall.sv]
// Top level: streaming grid maximum path sum with one straight wall.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------------
//  req_     | in        | req_tvalid / req_tready | tdata: cell_value
//  rsp_     | out       | rsp_tvalid / rsp_tready | tdata: best_sum, tuser: reachable
//  csr_     | in        | csr_valid / csr_ready   | csr_addr: register index, csr_wdata
//
//  One cell per cycle unless stalled: stage one reads the row buffer entry of the column,
//  stage two picks the upper or left sum, adds the cell and writes back; the left sum
//  loops through one register, the row buffer has one write and one read port.
//  The result is written to the output register when the final cell leaves stage two.
//  Synchronous reset clears position and valid flags and sets CSRs to 1; row buffer not cleared.
//  A held result stalls input only when the next final cell reaches stage two.
module grid_max_path_with_wall
   import gmp_pkg::*;
#(
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int SUM_BITS   = SUM_BITS_DEF,
   localparam int IN_W      = ((VALUE_BITS + 7) / 8) * 8,
   localparam int OUT_W     = ((SUM_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_W-1:0]          req_tdata,   // cell_value
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_W-1:0]         rsp_tdata,   // best_sum
   output logic                     rsp_tuser,   // reachable
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_BITS-1:0]      csr_wdata
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int XW  = (CW > RW) ? CW : RW;
   localparam int PW  = ((XW > CSR_BITS) ? XW : CSR_BITS) + 2;
   localparam int AW  = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
   localparam logic signed [AW-1:0] SAT_HI = signed'((AW'(1) << (SUM_BITS - 1)) - AW'(1));
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

   // configuration registers
   logic [CSR_BITS-1:0] num_rows_ff, num_cols_ff;
   logic [CSR_BITS-1:0] wall_row_a_ff, wall_col_a_ff, wall_row_b_ff, wall_col_b_ff;

   // position of the next cell
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   // stage two
   logic                         s1_valid_ff;
   logic signed [VALUE_BITS-1:0] s1_value_ff;
   logic [CW-1:0]                s1_col_ff;
   logic                         s1_start_ff, s1_up_en_ff, s1_left_en_ff, s1_last_ff;

   logic [SUM_BITS:0]            row_mem [MAX_COLS];
   logic [SUM_BITS:0]            rd_data_ff;
   logic                         fwd_hit_ff;
   logic [SUM_BITS:0]            fwd_data_ff;

   logic                         left_valid_ff;
   logic signed [SUM_BITS-1:0]   left_sum_ff;

   logic                         rsp_valid_ff;
   logic [SUM_BITS-1:0]          best_sum_ff;
   logic                         reachable_ff;

   // stage one decode
   logic [PW-1:0] rows_eff, cols_eff, r_pos, c_pos;
   logic [PW-1:0] wr_lo, wr_hi, wc_lo, wc_hi;
   logic          hwall, vwall, end_row, end_grid;
   logic          req_accept, s1_advance;

   // stage two datapath
   logic [SUM_BITS:0]          up_word;
   logic signed [SUM_BITS-1:0] up_sum, base_sum, cur_sum;
   logic                       up_ok, left_ok, cur_valid;
   logic signed [AW-1:0]       sum_wide;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff   <= CSR_BITS'(1);
         num_cols_ff   <= CSR_BITS'(1);
         wall_row_a_ff <= CSR_BITS'(1);
         wall_col_a_ff <= CSR_BITS'(1);
         wall_row_b_ff <= CSR_BITS'(1);
         wall_col_b_ff <= CSR_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_addr))
            REG_NUM_ROWS:   num_rows_ff   <= csr_wdata;
            REG_NUM_COLS:   num_cols_ff   <= csr_wdata;
            REG_WALL_ROW_A: wall_row_a_ff <= csr_wdata;
            REG_WALL_COL_A: wall_col_a_ff <= csr_wdata;
            REG_WALL_ROW_B: wall_row_b_ff <= csr_wdata;
            REG_WALL_COL_B: wall_col_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (num_rows_ff == '0)
         rows_eff = PW'(1);
      else if (PW'(num_rows_ff) > PW'(MAX_ROWS))
         rows_eff = PW'(MAX_ROWS);
      else
         rows_eff = PW'(num_rows_ff);
      if (num_cols_ff == '0)
         cols_eff = PW'(1);
      else if (PW'(num_cols_ff) > PW'(MAX_COLS))
         cols_eff = PW'(MAX_COLS);
      else
         cols_eff = PW'(num_cols_ff);

      r_pos = PW'(row_ff) + PW'(1);
      c_pos = PW'(col_ff) + PW'(1);
      wr_lo = (wall_row_a_ff < wall_row_b_ff) ? PW'(wall_row_a_ff) : PW'(wall_row_b_ff);
      wr_hi = (wall_row_a_ff > wall_row_b_ff) ? PW'(wall_row_a_ff) : PW'(wall_row_b_ff);
      wc_lo = (wall_col_a_ff < wall_col_b_ff) ? PW'(wall_col_a_ff) : PW'(wall_col_b_ff);
      wc_hi = (wall_col_a_ff > wall_col_b_ff) ? PW'(wall_col_a_ff) : PW'(wall_col_b_ff);

      hwall = (wall_row_a_ff == wall_row_b_ff) && (r_pos == PW'(wall_row_a_ff) + PW'(1))
              && (wc_lo < c_pos) && (c_pos <= wc_hi);
      vwall = !hwall && (wall_col_a_ff == wall_col_b_ff)
              && (c_pos == PW'(wall_col_a_ff) + PW'(1))
              && (wr_lo < r_pos) && (r_pos <= wr_hi);

      end_row  = (c_pos >= cols_eff);
      end_grid = end_row && (r_pos >= rows_eff);

      if (end_row) begin
         col_in = '0;
         row_in = end_grid ? '0 : RW'(r_pos);
      end else begin
         col_in = CW'(c_pos);
         row_in = row_ff;
      end
   end

   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_value_ff   <= signed'(req_tdata[VALUE_BITS-1:0]);
         s1_col_ff     <= col_ff;
         s1_start_ff   <= (row_ff == '0) && (col_ff == '0);
         s1_up_en_ff   <= (row_ff != '0) && !hwall;
         s1_left_en_ff <= (col_ff != '0) && !vwall;
         s1_last_ff    <= end_grid;
         fwd_hit_ff    <= s1_advance && (s1_col_ff == col_ff);
         fwd_data_ff   <= {cur_valid, cur_sum};
      end
   end

   // row buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (s1_advance)
         row_mem[s1_col_ff] <= {cur_valid, cur_sum};
      if (req_accept)
         rd_data_ff <= row_mem[col_ff];
   end

   always_comb begin
      up_word  = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      up_sum   = signed'(up_word[SUM_BITS-1:0]);
      up_ok    = s1_up_en_ff && up_word[SUM_BITS];
      left_ok  = s1_left_en_ff && left_valid_ff;
      if (s1_start_ff)
         base_sum = '0;
      else if (up_ok && left_ok)
         base_sum = (up_sum > left_sum_ff) ? up_sum : left_sum_ff;
      else if (up_ok)
         base_sum = up_sum;
      else
         base_sum = left_sum_ff;
      cur_valid = s1_start_ff || up_ok || left_ok;
      sum_wide  = AW'(base_sum) + AW'(s1_value_ff);
      if (!cur_valid)
         cur_sum = '0;
      else if (sum_wide > SAT_HI)
         cur_sum = SUM_BITS'(SAT_HI);
      else if (sum_wide < SAT_LO)
         cur_sum = SUM_BITS'(SAT_LO);
      else
         cur_sum = SUM_BITS'(sum_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         left_valid_ff <= cur_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance)
         left_sum_ff <= cur_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         best_sum_ff  <= cur_sum;
         reachable_ff <= cur_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(best_sum_ff);
   assign rsp_tuser  = reachable_ff;

endmodule
